// File: hdl/josephus_elimination_order_macros.svh
// Assertion macros shared by the Josephus elimination order RTL.
// Every macro samples on the rising edge of clock and is idle while reset is high.
`ifndef JOSEPHUS_ELIMINATION_ORDER_MACROS_SVH
`define JOSEPHUS_ELIMINATION_ORDER_MACROS_SVH

// Same-cycle implication.
`define JOS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Implication checked in the next cycle.
`define JOS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/jos_pkg.sv
// Shared types and constants for the Josephus elimination order block.
// Used by jos_ctrl, jos_dpath and the top level; depends on nothing.
package jos_pkg;

   localparam int MEMBER_W = 7;   // member_count and eliminated_member width
   localparam int RSP_W    = 8;   // result tdata width, whole bytes

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_LOOKUP,
      ST_FOLLOW,
      ST_LINK,
      ST_LAST_RD,
      ST_LAST_OUT
   } jos_state_type;

   // Read address source for the next-member memory.
   typedef enum logic [1:0] {
      RD_PREV,
      RD_DATA,
      RD_VICTIM
   } jos_rd_sel_type;

   typedef struct packed {
      logic           load;
      logic           init_wr;
      logic           start_run;
      logic           walk_start;
      logic           follow_step;
      logic           take_victim;
      logic           link_emit;
      logic           last_emit;
      jos_rd_sel_type rd_sel;
   } jos_cmd_type;

   typedef struct packed {
      logic n_zero;
      logic init_last;
      logic one_member;
      logic walk_done;
      logic two_left;
      logic out_free;
   } jos_status_type;

endpackage

// File: hdl/jos_ctrl.sv
// Controller state machine for the Josephus elimination order block.
// Depends on jos_pkg; drives the datapath through jos_cmd_type.
module jos_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  jos_pkg::jos_status_type status,
   output jos_pkg::jos_cmd_type    cmd
);

   jos_pkg::jos_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= jos_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         jos_pkg::ST_IDLE: begin
            if (req_tvalid && !status.n_zero) begin
               state_in = jos_pkg::ST_INIT;
            end
         end
         jos_pkg::ST_INIT: begin
            if (status.init_last) begin
               state_in = status.one_member ? jos_pkg::ST_LAST_RD : jos_pkg::ST_LOOKUP;
            end
         end
         jos_pkg::ST_LOOKUP: begin
            state_in = jos_pkg::ST_FOLLOW;
         end
         jos_pkg::ST_FOLLOW: begin
            if (status.walk_done) begin
               state_in = jos_pkg::ST_LINK;
            end
         end
         jos_pkg::ST_LINK: begin
            if (status.out_free) begin
               state_in = status.two_left ? jos_pkg::ST_LAST_RD : jos_pkg::ST_LOOKUP;
            end
         end
         jos_pkg::ST_LAST_RD: begin
            state_in = jos_pkg::ST_LAST_OUT;
         end
         jos_pkg::ST_LAST_OUT: begin
            if (status.out_free) begin
               state_in = jos_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = jos_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.rd_sel = jos_pkg::RD_PREV;
      req_tready = 1'b0;
      unique case (state_ff)
         jos_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid && !status.n_zero;
         end
         jos_pkg::ST_INIT: begin
            cmd.init_wr   = 1'b1;
            cmd.start_run = status.init_last;
         end
         jos_pkg::ST_LOOKUP: begin
            cmd.walk_start = 1'b1;
         end
         jos_pkg::ST_FOLLOW: begin
            // Each cycle either follows one more link or takes the victim;
            // both feed the freshly read entry back as the next address.
            cmd.rd_sel      = jos_pkg::RD_DATA;
            cmd.follow_step = !status.walk_done;
            cmd.take_victim = status.walk_done;
         end
         jos_pkg::ST_LINK: begin
            cmd.rd_sel    = jos_pkg::RD_VICTIM;
            cmd.link_emit = status.out_free;
         end
         jos_pkg::ST_LAST_RD: begin
            cmd.rd_sel = jos_pkg::RD_PREV;
         end
         jos_pkg::ST_LAST_OUT: begin
            cmd.rd_sel    = jos_pkg::RD_PREV;
            cmd.last_emit = status.out_free;
         end
         default: begin
            cmd.rd_sel = jos_pkg::RD_PREV;
         end
      endcase
   end

endmodule

// File: hdl/jos_dpath.sv
// Datapath for the Josephus elimination order block: next-member memory,
// ring pointers, step counter and the result register. Depends on jos_pkg.
module jos_dpath #(
   parameter int MAX_MEMBERS = 64,
   parameter int STEP_BITS   = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [jos_pkg::MEMBER_W-1:0]     member_count,
   input  logic [STEP_BITS-1:0]             step_size,
   input  jos_pkg::jos_cmd_type             cmd,
   output jos_pkg::jos_status_type          status,
   input  logic                             rsp_tready,
   output logic                             rsp_tvalid,
   output logic [jos_pkg::MEMBER_W-1:0]     eliminated_member,
   output logic                             last_of_run
);

   localparam int IDX_W = $clog2(MAX_MEMBERS);
   localparam int CNT_W = $clog2(MAX_MEMBERS + 1);

   logic [IDX_W-1:0]     next_mem [MAX_MEMBERS];
   logic [IDX_W-1:0]     rd_data_ff;
   logic [IDX_W-1:0]     rd_addr;
   logic                 mem_we;
   logic [IDX_W-1:0]     mem_wa;
   logic [IDX_W-1:0]     mem_wd;

   logic [CNT_W-1:0]     n_ff, n_in;
   logic [STEP_BITS-1:0] m_ff, m_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [IDX_W-1:0]     prev_ff, prev_in;
   logic [IDX_W-1:0]     victim_ff, victim_in;
   logic [STEP_BITS-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0]     remaining_ff, remaining_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [jos_pkg::MEMBER_W-1:0] rsp_member_ff, rsp_member_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [CNT_W-1:0]     n_last;
   logic [CNT_W-1:0]     idx_succ;
   logic [IDX_W-1:0]     init_data;
   logic                 out_free;

   assign n_last    = n_ff - CNT_W'(1);
   assign idx_succ  = CNT_W'(idx_ff) + CNT_W'(1);
   assign init_data = (idx_succ < n_ff) ? IDX_W'(idx_succ) : '0;
   assign out_free  = !rsp_valid_ff || rsp_tready;

   assign status.n_zero     = (member_count == '0);
   assign status.init_last  = (CNT_W'(idx_ff) == n_last);
   assign status.one_member = (n_ff == CNT_W'(1));
   assign status.walk_done  = (cnt_ff == m_ff);
   assign status.two_left   = (remaining_ff == CNT_W'(2));
   assign status.out_free   = out_free;

   always_comb begin
      case (cmd.rd_sel)
         jos_pkg::RD_DATA:   rd_addr = rd_data_ff;
         jos_pkg::RD_VICTIM: rd_addr = victim_ff;
         default:            rd_addr = prev_ff;
      endcase
      mem_we = cmd.init_wr || cmd.link_emit;
      mem_wa = cmd.init_wr ? idx_ff : prev_ff;
      // Unlinking the victim: its predecessor now points past it.
      mem_wd = cmd.init_wr ? init_data : rd_data_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         next_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= next_mem[rd_addr];
   end

   always_comb begin
      n_in          = n_ff;
      m_in          = m_ff;
      idx_in        = idx_ff;
      prev_in       = prev_ff;
      victim_in     = victim_ff;
      cnt_in        = cnt_ff;
      remaining_in  = remaining_ff;
      rsp_member_in = rsp_member_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;

      if (cmd.load) begin
         // Counts above the ring size saturate; a zero step counts as one.
         n_in   = (member_count > jos_pkg::MEMBER_W'(MAX_MEMBERS)) ?
                  CNT_W'(MAX_MEMBERS) : CNT_W'(member_count);
         m_in   = (step_size == '0) ? STEP_BITS'(1) : step_size;
         idx_in = '0;
      end
      if (cmd.init_wr) begin
         idx_in = idx_ff + IDX_W'(1);
      end
      if (cmd.start_run) begin
         prev_in      = IDX_W'(n_last);
         remaining_in = n_ff;
      end
      if (cmd.walk_start) begin
         cnt_in = STEP_BITS'(1);
      end
      if (cmd.follow_step) begin
         prev_in = rd_data_ff;
         cnt_in  = cnt_ff + STEP_BITS'(1);
      end
      if (cmd.take_victim) begin
         victim_in = rd_data_ff;
      end
      if (cmd.link_emit) begin
         remaining_in  = remaining_ff - CNT_W'(1);
         rsp_valid_in  = 1'b1;
         rsp_member_in = jos_pkg::MEMBER_W'(victim_ff) + jos_pkg::MEMBER_W'(1);
         rsp_last_in   = 1'b0;
      end
      if (cmd.last_emit) begin
         rsp_valid_in  = 1'b1;
         rsp_member_in = jos_pkg::MEMBER_W'(rd_data_ff) + jos_pkg::MEMBER_W'(1);
         rsp_last_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= '0;
         remaining_ff <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         prev_ff      <= prev_in;
         remaining_ff <= remaining_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff          <= n_in;
      m_ff          <= m_in;
      idx_ff        <= idx_in;
      victim_ff     <= victim_in;
      rsp_member_ff <= rsp_member_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid        = rsp_valid_ff;
   assign eliminated_member = rsp_member_ff;
   assign last_of_run       = rsp_last_ff;

endmodule

// File: hdl/josephus_elimination_order.sv
// Channel  | Ports          | Item
// ---------+----------------+--------------------------------------------------
// request  | req_t*         | member_count, step_size: one Josephus problem
// response | rsp_t*         | eliminated_member per removal, tlast on survivor
//
// One request of n members and step m first builds the ring, then follows one
// ring link per cycle, unless a stalled response holds the walk, through the
// next-member memory with its registered read.
// A request of zero members is accepted and gives no items.
// Reset is synchronous; the ring memory is not cleared and needs no sweep.
// A stalled response holds the walk at the next removal; the result register
// lets the block finish its last item and take a new request meanwhile.
// Depends on jos_pkg, jos_ctrl, jos_dpath and the assertion macro header.
`include "josephus_elimination_order_macros.svh"

module josephus_elimination_order #(
   parameter int MAX_MEMBERS = 64,
   parameter int STEP_BITS   = 8
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // [6:0] member_count, [STEP_BITS+6:7] step_size, zero padding above
   input  logic [((jos_pkg::MEMBER_W + STEP_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // [6:0] eliminated_member, [7] zero
   output logic [jos_pkg::RSP_W-1:0]               rsp_tdata,
   output logic                                    rsp_tlast
);

   jos_pkg::jos_cmd_type         cmd;
   jos_pkg::jos_status_type      status;
   logic [jos_pkg::MEMBER_W-1:0] member_count;
   logic [STEP_BITS-1:0]         step_size;
   logic [jos_pkg::MEMBER_W-1:0] eliminated_member;
   logic                         emit_any;
   logic                         rsp_room;
   logic                         req_load;
   logic                         last_held;

   assign member_count = req_tdata[jos_pkg::MEMBER_W-1:0];
   assign step_size    = req_tdata[jos_pkg::MEMBER_W +: STEP_BITS];
   assign rsp_tdata    = jos_pkg::RSP_W'(eliminated_member);

   jos_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   jos_dpath #(
      .MAX_MEMBERS (MAX_MEMBERS),
      .STEP_BITS   (STEP_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .member_count      (member_count),
      .step_size         (step_size),
      .cmd               (cmd),
      .status            (status),
      .rsp_tready        (rsp_tready),
      .rsp_tvalid        (rsp_tvalid),
      .eliminated_member (eliminated_member),
      .last_of_run       (rsp_tlast)
   );

   assign emit_any  = cmd.link_emit || cmd.last_emit;
   assign rsp_room  = !rsp_tvalid || rsp_tready;
   assign req_load  = req_tvalid && req_tready && !status.n_zero;
   assign last_held = req_tready && rsp_tvalid && rsp_tlast;

   // A new result is only loaded when the pending one is gone or leaving.
   `JOS_ASSERT_NOW(a_emit_needs_room, emit_any, rsp_room, "result register overwritten")
   // A nonempty request keeps the block busy in the next cycle.
   `JOS_ASSERT_NEXT(a_busy_after_load, req_load, !req_tready, "request taken while busy")
   // After the survivor is given the block is ready for the next request.
   `JOS_ASSERT_NEXT(a_ready_after_last, cmd.last_emit, last_held, "survivor not held")

endmodule
